// ===== src/modexp_pkg.sv =====
package modexp_pkg;

  // operand widths
  localparam int MODULUS_BITS  = 32;
  localparam int EXPONENT_BITS = 63;
  localparam int BASE_W        = 63;
  localparam int RESULT_W      = 32;

  // dividend shift register holds a full base or the low half of a double-width product
  localparam int DIV_W     = BASE_W + 1;
  localparam int PROD_W    = 2 * MODULUS_BITS;
  localparam int CNT_W     = $clog2(DIV_W + 1);
  localparam int BIT_CNT_W = $clog2(EXPONENT_BITS);

  // operations of the shared mul/reduce unit
  localparam logic OP_REDUCE = 1'b0;
  localparam logic OP_MULMOD = 1'b1;

  typedef struct packed {
    logic go;
    logic op;
  } mm_req_t;

endpackage

// ===== src/modexp_mmu.sv =====
module modexp_mmu import modexp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mm_req_t                 req,
  input  logic [MODULUS_BITS-1:0] op_a,
  input  logic [MODULUS_BITS-1:0] op_b,
  input  logic [MODULUS_BITS-1:0] modulus,
  input  logic [BASE_W-1:0]       base,
  output logic                    done,
  output logic [MODULUS_BITS-1:0] result
);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_RED  = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    done_r, done_nxt;
  logic [PROD_W-1:0]       prod_r;
  logic [DIV_W-1:0]        div_r;
  logic [MODULUS_BITS-1:0] rem_r;

  logic [MODULUS_BITS:0] trial;
  logic [MODULUS_BITS:0] trial_sub;

  // one restoring step: shift in a dividend bit, subtract if it fits
  always_comb begin
    trial     = {rem_r, div_r[DIV_W-1]};
    trial_sub = (trial >= {1'b0, modulus}) ? (trial - {1'b0, modulus}) : trial;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      U_IDLE: begin
        if (req.go) begin
          if (req.op == OP_MULMOD) begin
            state_nxt = U_MUL;
          end else begin
            state_nxt = U_RED;
            cnt_nxt   = CNT_W'(DIV_W);
          end
        end
      end
      U_MUL: begin
        state_nxt = U_RED;
        cnt_nxt   = CNT_W'(MODULUS_BITS);
      end
      U_RED: begin
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = U_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      U_IDLE: begin
        if (req.go) begin
          prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
          rem_r  <= '0;
          div_r  <= {1'b0, base};
        end
      end
      U_MUL: begin
        // high half of a product of reduced operands is already below the modulus
        rem_r <= prod_r[PROD_W-1:MODULUS_BITS];
        div_r <= {prod_r[MODULUS_BITS-1:0], {(DIV_W-MODULUS_BITS){1'b0}}};
      end
      U_RED: begin
        rem_r <= trial_sub[MODULUS_BITS-1:0];
        div_r <= div_r << 1;
      end
      default: begin
      end
    endcase
  end

  assign done   = done_r;
  assign result = rem_r;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r == U_IDLE)
    else $error("done raised while unit still working");
  a_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |-> state_r == U_IDLE)
    else $error("request issued to a busy unit");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && modulus != '0) |-> rem_r < modulus)
    else $error("remainder not reduced");
`endif

endmodule

// ===== src/modular_exponentiation.sv =====
// modular exponentiation: out_result = in_base ** in_exponent mod in_modulus, by
// left-to-right square-and-multiply over all EXPONENT_BITS exponent bits. a request
// is taken when start is high and busy is low; the answer appears on out_result
// for exactly one cycle with out_valid high, and the receiver cannot stall it.
// an exponent of zero answers 1 (any modulus) and a modulus of zero answers 0;
// both come back in the cycle after the request. otherwise the work is done
// by one shared unit that does a 32x32 multiply and then a bit-serial restoring
// reduction, one remainder bit per cycle: 64 steps to reduce the base once,
// 32 steps for every square and every multiply. busy stays high for the whole
// computation.
module modular_exponentiation import modexp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [BASE_W-1:0]   in_base,
  input  logic [62:0]         in_exponent,
  input  logic [31:0]         in_modulus,
  output logic                out_valid,
  output logic [RESULT_W-1:0] out_result
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request
  localparam logic [1:0] S_BASE = 2'd1;  // reducing the base
  localparam logic [1:0] S_SQR  = 2'd2;  // squaring the accumulator
  localparam logic [1:0] S_MUL  = 2'd3;  // multiplying by the reduced base

  logic [1:0]               state_r, state_nxt;
  mm_req_t                  req_r, req_nxt;
  logic [MODULUS_BITS-1:0]  opa_r, opa_nxt;
  logic [MODULUS_BITS-1:0]  opb_r, opb_nxt;
  logic [MODULUS_BITS-1:0]  b_r, b_nxt;        // base mod modulus
  logic [MODULUS_BITS-1:0]  mod_r, mod_nxt;
  logic [BASE_W-1:0]        base_r, base_nxt;
  logic [EXPONENT_BITS-1:0] exp_r, exp_nxt;    // top bit is the current bit
  logic [BIT_CNT_W-1:0]     bit_cnt_r, bit_cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [RESULT_W-1:0]      out_result_r, out_result_nxt;
  logic                     step;

  logic                     mm_done;
  logic [MODULUS_BITS-1:0]  mm_result;

  // shared multiply / modular reduce unit
  modexp_mmu u_mmu (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req_r),
    .op_a    (opa_r),
    .op_b    (opb_r),
    .modulus (mod_r),
    .base    (base_r),
    .done    (mm_done),
    .result  (mm_result)
  );

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = '0;
    opa_nxt        = opa_r;
    opb_nxt        = opb_r;
    b_nxt          = b_r;
    mod_nxt        = mod_r;
    base_nxt       = base_r;
    exp_nxt        = exp_r;
    bit_cnt_nxt    = bit_cnt_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    step           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          exp_nxt     = in_exponent[EXPONENT_BITS-1:0];
          mod_nxt     = in_modulus[MODULUS_BITS-1:0];
          base_nxt    = in_base;
          bit_cnt_nxt = BIT_CNT_W'(EXPONENT_BITS - 1);
          if (in_exponent[EXPONENT_BITS-1:0] == '0) begin
            // zero exponent gives one for every modulus
            out_valid_nxt  = 1'b1;
            out_result_nxt = RESULT_W'(1);
          end else if (in_modulus[MODULUS_BITS-1:0] == '0) begin
            // no reduction possible, answer zero
            out_valid_nxt  = 1'b1;
            out_result_nxt = '0;
          end else begin
            state_nxt  = S_BASE;
            req_nxt.go = 1'b1;
            req_nxt.op = OP_REDUCE;
          end
        end
      end
      S_BASE: begin
        if (mm_done) begin
          // accumulator starts at one: first square is 1*1
          b_nxt      = mm_result;
          state_nxt  = S_SQR;
          req_nxt.go = 1'b1;
          req_nxt.op = OP_MULMOD;
          opa_nxt    = MODULUS_BITS'(1);
          opb_nxt    = MODULUS_BITS'(1);
        end
      end
      S_SQR: begin
        if (mm_done) begin
          if (exp_r[EXPONENT_BITS-1]) begin
            state_nxt  = S_MUL;
            req_nxt.go = 1'b1;
            req_nxt.op = OP_MULMOD;
            opa_nxt    = mm_result;
            opb_nxt    = b_r;
          end else begin
            step = 1'b1;
          end
        end
      end
      S_MUL: begin
        if (mm_done) begin
          step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // move on to the next exponent bit, or finish after the last one
    if (step) begin
      exp_nxt = exp_r << 1;
      if (bit_cnt_r == '0) begin
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_result_nxt = RESULT_W'(mm_result);
      end else begin
        bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
        state_nxt   = S_SQR;
        req_nxt.go  = 1'b1;
        req_nxt.op  = OP_MULMOD;
        opa_nxt     = mm_result;
        opb_nxt     = mm_result;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      req_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      req_r       <= req_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    opa_r        <= opa_nxt;
    opb_r        <= opb_nxt;
    b_r          <= b_nxt;
    mod_r        <= mod_nxt;
    base_r       <= base_nxt;
    exp_r        <= exp_nxt;
    bit_cnt_r    <= bit_cnt_nxt;
    out_result_r <= out_result_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

`ifndef SYNTHESIS
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe while still computing");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mm_done |-> busy)
    else $error("unit finished with no request in flight");
  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// checks modular_exponentiation against a square-and-multiply predictor:
// a directed set of corner requests, then random requests with a mix of
// wide and narrow operands, sent in bursts with random gaps
module tb_top;
  import modexp_pkg::*;

  localparam int N_RANDOM   = 121;
  // idle limit for the watchdog, several times the slowest request
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [BASE_W-1:0] base;
    logic [62:0]       exponent;
    logic [31:0]       modulus;
    bit                drain;   // hold this request until every answer is back
  } power_req_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [BASE_W-1:0]   in_base = '0;
  logic [62:0]         in_exponent = '0;
  logic [31:0]         in_modulus = '0;
  logic                out_valid;
  logic [RESULT_W-1:0] out_result;

  power_req_t          req_q[$];     // requests not yet sent
  logic [RESULT_W-1:0] power_q[$];   // expected answers, oldest first

  int n_sent = 0;
  int n_checked = 0;
  int n_queued = 0;
  int n_fail = 0;
  int n_exp_zero = 0;
  int n_mod_low = 0;
  int n_drain = 0;
  int gap_left = 0;
  int burst_left = 1;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  modular_exponentiation u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_base    (in_base),
    .in_exponent(in_exponent),
    .in_modulus (in_modulus),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  // left-to-right square-and-multiply over all 63 exponent bits;
  // every operand stays below 2^32, so each product fits in 64 bits
  function automatic logic [RESULT_W-1:0] expected_power(logic [BASE_W-1:0] b,
                                                         logic [62:0] e,
                                                         logic [31:0] m);
    bit [63:0] m64;
    bit [63:0] b_red;
    bit [63:0] acc;
    if (e[EXPONENT_BITS-1:0] == '0) return RESULT_W'(1);
    m64 = {32'd0, m[MODULUS_BITS-1:0]};
    // no reduction possible with a zero modulus
    if (m64 == 0) return '0;
    b_red = {1'b0, b} % m64;
    acc = 64'd1;
    for (int i = EXPONENT_BITS - 1; i >= 0; i--) begin
      acc = (acc * acc) % m64;
      if (e[i]) acc = (acc * b_red) % m64;
    end
    return acc[RESULT_W-1:0];
  endfunction

  function automatic logic [62:0] rand63();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[62:0];
  endfunction

  task automatic add_req(logic [BASE_W-1:0] b, logic [62:0] e, logic [31:0] m, bit drain);
    power_req_t r;
    r.base = b;
    r.exponent = e;
    r.modulus = m;
    r.drain = drain;
    req_q.insert(req_q.size(), r);
    if (e == 0) n_exp_zero++;
    if (m <= 1) n_mod_low++;
    if (drain) n_drain++;
  endtask

  // driver: a new request goes out once the previous one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        power_q.insert(power_q.size(), expected_power(in_base, in_exponent, in_modulus));
        n_sent++;
      end
      // channel is free unless a request is still waiting on busy
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (req_q.size() == 0) begin
          start <= 1'b0;
        end else if (req_q[0].drain && power_q.size() != 0) begin
          // hold off until the block has answered everything
          start <= 1'b0;
        end else begin
          power_req_t r;
          r = req_q.pop_front();
          in_base <= r.base;
          in_exponent <= r.exponent;
          in_modulus <= r.modulus;
          start <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            // mostly short gaps, some long, some none at all
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(5, 60);
              default: gap_left = $urandom_range(1, 3);
            endcase
          end
        end
      end
    end
  end

  // monitor: answers can't be stalled, so each strobe is checked on the spot
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (power_q.size() == 0) begin
        $error("unexpected answer: out_result actual %0h", out_result);
        n_fail++;
      end else begin
        logic [RESULT_W-1:0] want;
        want = power_q.pop_front();
        n_checked++;
        if (out_result !== want) begin
          $error("out_result mismatch: expected %0h actual %0h", want, out_result);
          n_fail++;
        end
      end
    end
  end

  // watchdog on cycles with neither a request taken nor an answer seen
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d answers outstanding",
               idle_cycles, power_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0] m;
    logic [62:0] e;
    logic [62:0] b;
    int          k;

    // directed corners
    add_req(63'd5, 63'd0, 32'd0, 1'b0);                       // zero exponent, zero modulus
    add_req(63'd5, 63'd0, 32'd1, 1'b0);                       // zero exponent, modulus one
    add_req({63{1'b1}}, 63'd0, 32'hFFFF_FFFF, 1'b0);          // zero exponent, widest modulus
    add_req(63'd12345, 63'd7, 32'd1, 1'b0);                   // modulus one
    add_req(63'd12345, 63'd7, 32'd0, 1'b0);                   // zero modulus
    add_req({63{1'b1}}, {63{1'b1}}, 32'd0, 1'b0);
    add_req(63'd1000, 63'd1, 32'd7, 1'b0);                    // exponent one, base above modulus
    add_req({63{1'b1}}, 63'd1, 32'hFFFF_FFFF, 1'b0);
    add_req(63'd0, 63'd9, 32'd13, 1'b0);                      // zero base
    add_req(63'd0, {63{1'b1}}, 32'hFFFF_FFFF, 1'b0);
    add_req({63{1'b1}}, {63{1'b1}}, 32'hFFFF_FFFF, 1'b0);     // everything at the top
    add_req(63'd2, 63'd10, 32'd1000, 1'b0);                   // 24
    add_req(63'd3, 63'd65536, 32'd65537, 1'b0);
    add_req(63'd7, 63'd1 << 62, 32'hFFFF_FFFB, 1'b0);         // only the top exponent bit
    add_req(63'd3, 63'd5, 32'd2, 1'b0);                       // odd base, even modulus
    add_req(63'd6, 63'd3, 32'h8000_0000, 1'b0);               // power-of-two modulus
    add_req(63'h7FFF_FFFF_FFFF_FFFE, 63'd2, 32'hFFFF_FFFE, 1'b1);
    add_req(63'd1, {63{1'b1}}, 32'd97, 1'b0);
    add_req(63'd96, 63'd3, 32'd97, 1'b0);                     // base of modulus - 1

    // random part
    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(0, 9))
        0: m = 32'd0;
        1: m = 32'd1;
        2: m = $urandom_range(2, 255);
        3: m = 32'hFFFF_FFFF - $urandom_range(0, 15);
        4: m = 32'd1 << $urandom_range(0, 31);
        default: m = $urandom();
      endcase
      case ($urandom_range(0, 9))
        0: e = 63'd0;
        1: e = 63'($urandom_range(1, 20));
        2: e = {63{1'b1}};
        3: e = 63'd1 << $urandom_range(0, 62);
        default: e = rand63();
      endcase
      k = $urandom_range(0, 7);
      case (k)
        0: b = 63'd0;
        1: b = 63'($urandom_range(1, 300));
        2: b = {31'd0, m} * 63'($urandom_range(1, 1000));     // multiple of the modulus
        3: b = {63{1'b1}};
        default: b = rand63();
      endcase
      add_req(b, e, m, (n == 0) || ($urandom_range(0, 19) == 0));
    end
    n_queued = req_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (n_checked < n_queued) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d answers checked", n_sent, n_checked);
    $display("%0d with zero exponent, %0d with modulus 0 or 1, %0d drain pauses",
             n_exp_zero, n_mod_low, n_drain);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
